/* sv/jac_pkg.sv */
// shared types and constants for the 7-point jacobi sweep block
// no dependencies; imported by every module of the block but jac_ram
package jac_pkg;

	localparam int MAX_X      = 64;
	localparam int MAX_Y      = 64;
	localparam int MAX_Z      = 64;
	localparam int VALUE_BITS = 32;
	localparam int SIZE_W     = 7;
	localparam int COORD_W    = 6;
	localparam int PLANE_W    = $clog2(MAX_X * MAX_Y + 1);
	localparam int WIN_DEPTH  = 2 * MAX_X * MAX_Y + 1;
	localparam int WIN_AW     = $clog2(WIN_DEPTH);
	localparam int CELL_W     = 2 * VALUE_BITS + 1;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_X   = 3'd0,
		REG_SIZE_Y   = 3'd1,
		REG_SIZE_Z   = 3'd2,
		REG_ALPHA    = 3'd3,
		REG_INV_BETA = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] field_value;
		logic signed [VALUE_BITS-1:0] rhs_value;
		logic                         solid;
		logic                         is_padding;
	} in_beat_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] new_value;
		logic                         last_cell;
	} out_beat_t;

	// controller to datapath
	typedef struct packed {
		logic              wr;
		logic [WIN_AW-1:0] waddr;
		logic              wzero;
		logic              rd;
		logic [WIN_AW-1:0] raddr;
		logic              cap_center;
		logic              add_nb;
		logic              step_mul1;
		logic              step_sum;
		logic              step_abs;
		logic              step_mul2;
		logic              load_out;
		logic              boundary;
		logic              last;
	} jac_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} jac_sts_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] mx);
		logic [SIZE_W-1:0] r;
		begin
			if (v < SIZE_W'(3)) r = SIZE_W'(3);
			else if (v > mx) r = mx;
			else r = v;
			return r;
		end
	endfunction

endpackage

/* sv/jacobi_7pt_stencil_sweep.sv */
// top level of the 7-point jacobi sweep: configuration registers and the
// controller and datapath instances; uses jac_pkg, jac_ctrl, jac_dp
//
// One Jacobi relaxation pass of a 3-D 7-point stencil over a grid streamed in
// raster order, x fastest. Values are signed Q16.16; alpha and inv_beta are
// unsigned Q16.16. A sweep takes sx*sy*sz grid beats followed by sx*sy padding
// beats; results start once one plane has been taken and the result carrying
// last_cell ends the sweep. Beats of the first plane are only stored, with the
// controller left idle. A beat that yields a result goes through the accepting
// cycle, seven reads of the centre and its six neighbours through the single
// read port of the window ram, a wait for the last read data, four arithmetic
// steps (two 34x16 multiplies, a wide add, a magnitude, two 48x16 multiplies)
// and the load of the output register once free; the result waits there while
// the next beat is taken. Writing a size register restarts the sweep. The user
// must write configuration only while the block is idle; it is not enforced.
module jacobi_7pt_stencil_sweep (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  jac_pkg::in_beat_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output jac_pkg::out_beat_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [jac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import jac_pkg::*;

	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [31:0]       alpha_q, inv_beta_q;
	logic [SIZE_W-1:0] sx, sy, sz;
	logic              cfg_wr, restart;
	jac_cmd_t          cmd;
	jac_sts_t          sts;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign restart   = cfg_wr && (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y ||
	                              cfg_index == REG_SIZE_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q   <= SIZE_W'(MAX_X);
			size_y_q   <= SIZE_W'(MAX_Y);
			size_z_q   <= SIZE_W'(MAX_Z);
			alpha_q    <= 32'd65536;
			inv_beta_q <= 32'd10923;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_SIZE_X:   size_x_q   <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Y:   size_y_q   <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Z:   size_z_q   <= cfg_data[SIZE_W-1:0];
				REG_ALPHA:    alpha_q    <= cfg_data;
				REG_INV_BETA: inv_beta_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sx = clamp_size(size_x_q, SIZE_W'(MAX_X));
	assign sy = clamp_size(size_y_q, SIZE_W'(MAX_Y));
	assign sz = clamp_size(size_z_q, SIZE_W'(MAX_Z));

	jac_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_padding (in_data.is_padding),
		.restart    (restart),
		.sx         (sx),
		.sy         (sy),
		.sz         (sz),
		.sts        (sts),
		.cmd        (cmd)
	);

	jac_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.alpha     (alpha_q),
		.inv_beta  (inv_beta_q),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* sv/jac_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module jac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

/* sv/jac_ctrl.sv */
// sequencer for the jacobi sweep: stream position, centre coordinates,
// window addressing and per-cell step sequence; uses jac_pkg
module jac_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       in_padding,
	input  logic                       restart,
	input  logic [jac_pkg::SIZE_W-1:0] sx,
	input  logic [jac_pkg::SIZE_W-1:0] sy,
	input  logic [jac_pkg::SIZE_W-1:0] sz,
	input  jac_pkg::jac_sts_t          sts,
	output jac_pkg::jac_cmd_t          cmd
);
	import jac_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_MUL1, ST_SUM, ST_ABS, ST_MUL2, ST_OUT
	} state_t;

	state_t               state_q;
	logic [2:0]           rd_idx_q;
	logic [WIN_AW-1:0]    p_mod_q;
	logic [WIN_AW-1:0]    c_mod_q;
	logic [PLANE_W-1:0]   pre_cnt_q;
	logic                 primed_q;
	logic [COORD_W-1:0]   cx_q, cy_q, cz_q;

	logic [PLANE_W-1:0]   plane;
	logic                 accept;
	logic                 boundary, last, past_grid;
	logic [PLANE_W-1:0]   off;
	logic                 off_neg;
	logic [WIN_AW:0]      a_sum, a_dif;
	logic [WIN_AW-1:0]    nb_addr, p_next, c_next;

	assign plane  = PLANE_W'(sx) * PLANE_W'(sy);
	assign accept = in_valid && in_ready;

	assign boundary = (cx_q == '0) || ({1'b0, cx_q} == sx - 1'b1) ||
	                  (cy_q == '0) || ({1'b0, cy_q} == sy - 1'b1) ||
	                  (cz_q == '0) || ({1'b0, cz_q} == sz - 1'b1);
	assign last      = ({1'b0, cx_q} == sx - 1'b1) && ({1'b0, cy_q} == sy - 1'b1) &&
	                   ({1'b0, cz_q} == sz - 1'b1);
	// leading cell lies beyond the grid once the centre is in the last plane
	assign past_grid = primed_q && ({1'b0, cz_q} == sz - 1'b1);

	// neighbour order: centre, x-1, x+1, y-1, y+1, z-1, z+1
	always_comb begin
		off     = '0;
		off_neg = 1'b0;
		case (rd_idx_q)
			3'd1: begin off = PLANE_W'(1); off_neg = 1'b1; end
			3'd2: off = PLANE_W'(1);
			3'd3: begin off = PLANE_W'(sx); off_neg = 1'b1; end
			3'd4: off = PLANE_W'(sx);
			3'd5: begin off = plane; off_neg = 1'b1; end
			3'd6: off = plane;
			default: off = '0;
		endcase
	end

	always_comb begin
		a_sum = {1'b0, c_mod_q} + (WIN_AW+1)'(off);
		a_dif = {1'b0, c_mod_q} - (WIN_AW+1)'(off);
		if (off_neg) begin
			if (c_mod_q < WIN_AW'(off)) nb_addr = WIN_AW'(a_dif + (WIN_AW+1)'(WIN_DEPTH));
			else nb_addr = a_dif[WIN_AW-1:0];
		end else begin
			if (a_sum >= (WIN_AW+1)'(WIN_DEPTH)) nb_addr = WIN_AW'(a_sum - (WIN_AW+1)'(WIN_DEPTH));
			else nb_addr = a_sum[WIN_AW-1:0];
		end
	end

	assign p_next = (p_mod_q == WIN_AW'(WIN_DEPTH - 1)) ? '0 : p_mod_q + 1'b1;
	assign c_next = (c_mod_q == WIN_AW'(WIN_DEPTH - 1)) ? '0 : c_mod_q + 1'b1;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.wr         = accept;
		cmd.waddr      = p_mod_q;
		cmd.wzero      = in_padding || past_grid;
		cmd.rd         = (state_q == ST_READ) && (rd_idx_q != 3'd7);
		cmd.raddr      = nb_addr;
		cmd.cap_center = (state_q == ST_READ) && (rd_idx_q == 3'd1);
		cmd.add_nb     = (state_q == ST_READ) && (rd_idx_q >= 3'd2);
		cmd.step_mul1  = (state_q == ST_MUL1);
		cmd.step_sum   = (state_q == ST_SUM);
		cmd.step_abs   = (state_q == ST_ABS);
		cmd.step_mul2  = (state_q == ST_MUL2);
		cmd.load_out   = (state_q == ST_OUT) && sts.out_free;
		cmd.boundary   = boundary;
		cmd.last       = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_idx_q  <= '0;
			p_mod_q   <= '0;
			c_mod_q   <= '0;
			pre_cnt_q <= '0;
			primed_q  <= 1'b0;
			cx_q      <= '0;
			cy_q      <= '0;
			cz_q      <= '0;
		end else if (restart) begin
			state_q   <= ST_IDLE;
			rd_idx_q  <= '0;
			p_mod_q   <= '0;
			c_mod_q   <= '0;
			pre_cnt_q <= '0;
			primed_q  <= 1'b0;
			cx_q      <= '0;
			cy_q      <= '0;
			cz_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (primed_q) begin
							state_q  <= ST_READ;
							rd_idx_q <= '0;
						end else begin
							p_mod_q   <= p_next;
							pre_cnt_q <= pre_cnt_q + 1'b1;
							if (pre_cnt_q == plane - 1'b1) primed_q <= 1'b1;
						end
					end
				end
				ST_READ: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (rd_idx_q == 3'd7) state_q <= ST_MUL1;
				end
				ST_MUL1: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_ABS;
				ST_ABS:  state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_OUT;
				ST_OUT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						if (last) begin
							p_mod_q   <= '0;
							c_mod_q   <= '0;
							pre_cnt_q <= '0;
							primed_q  <= 1'b0;
							cx_q      <= '0;
							cy_q      <= '0;
							cz_q      <= '0;
						end else begin
							p_mod_q <= p_next;
							c_mod_q <= c_next;
							if ({1'b0, cx_q} == sx - 1'b1) begin
								cx_q <= '0;
								if ({1'b0, cy_q} == sy - 1'b1) begin
									cy_q <= '0;
									cz_q <= cz_q + 1'b1;
								end else begin
									cy_q <= cy_q + 1'b1;
								end
							end else begin
								cx_q <= cx_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_raddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (cmd.raddr < WIN_AW'(WIN_DEPTH)))
		else $error("window read address beyond store");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over a waiting beat");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && !restart) |=> in_ready)
		else $error("controller not back to idle after result");
	a_prefill: assert property (@(posedge clk) disable iff (!arst_n)
		(!primed_q && state_q != ST_IDLE) |-> restart)
		else $error("cell work started before first plane filled");

endmodule

/* sv/jac_dp.sv */
// datapath for the jacobi sweep: window store, neighbour sum, fixed-point
// relaxation with rounding and saturation, output register; uses jac_pkg, jac_ram
module jac_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  jac_pkg::in_beat_t    in_data,
	input  logic [31:0]          alpha,
	input  logic [31:0]          inv_beta,
	input  jac_pkg::jac_cmd_t    cmd,
	output jac_pkg::jac_sts_t    sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output jac_pkg::out_beat_t   out_data
);
	import jac_pkg::*;

	logic [CELL_W-1:0]     wdata, rdata;
	logic [VALUE_BITS-1:0] rd_fv, rd_rv;
	logic                  rd_obs;

	logic [VALUE_BITS-1:0] ctr_fv_q, ctr_rv_q;
	logic                  ctr_obs_q;
	logic signed [34:0]    sum_q;

	logic [34:0]           mag1;
	logic [49:0]           pa_s1, pb_s1;
	logic                  neg1_s1;
	logic [50:0]           t_w;
	logic signed [52:0]    s_s2;
	logic [52:0]           mag2;
	logic [47:0]           m_s3;
	logic                  neg_s3, big_s3, zero_s3;
	logic [63:0]           hi_s4, lo_s4;
	logic                  hi_over;
	logic [49:0]           r_w;
	logic [64:0]           lo_rnd;
	logic                  sat;
	logic [VALUE_BITS-1:0] relax_v, new_v;
	logic                  out_valid_q;
	out_beat_t             out_q;

	assign wdata = cmd.wzero ? '0 :
	               {in_data.solid, in_data.rhs_value, in_data.field_value};

	jac_ram #(.WIDTH(CELL_W), .DEPTH(WIN_DEPTH)) u_win (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (cmd.waddr),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (cmd.raddr),
		.rdata (rdata)
	);

	assign rd_fv  = rdata[VALUE_BITS-1:0];
	assign rd_rv  = rdata[2*VALUE_BITS-1:VALUE_BITS];
	assign rd_obs = rdata[CELL_W-1];

	assign mag1 = sum_q[34] ? 35'(-sum_q) : 35'(sum_q);
	assign t_w  = {1'b0, pa_s1} + 51'((51'(pb_s1) + 51'h8000) >> 16);
	assign mag2 = s_s2[52] ? 53'(-s_s2) : 53'(s_s2);

	// final rounding and clamp to the signed 32-bit range, then the boundary and solid-cell choice
	always_comb begin
		hi_over = |hi_s4[63:33];
		lo_rnd  = (65'(lo_s4) + 65'h8000) >> 16;
		r_w     = 50'(hi_s4[32:0]) + 50'(lo_rnd);
		sat     = big_s3 || hi_over;
		if (zero_s3) relax_v = '0;
		else if (neg_s3) begin
			if (sat || r_w > 50'h0_8000_0000) relax_v = 32'h8000_0000;
			else relax_v = 32'(0) - r_w[31:0];
		end else begin
			if (sat || r_w > 50'h0_7fff_ffff) relax_v = 32'h7fff_ffff;
			else relax_v = r_w[31:0];
		end
		if (cmd.boundary) new_v = ctr_fv_q;
		else if (ctr_obs_q) new_v = '0;
		else new_v = relax_v;
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_center) begin
			ctr_fv_q  <= rd_fv;
			ctr_rv_q  <= rd_rv;
			ctr_obs_q <= rd_obs;
			sum_q     <= '0;
		end else if (cmd.add_nb) begin
			sum_q <= sum_q + 35'(signed'(rd_fv));
		end
		if (cmd.step_mul1) begin
			pa_s1   <= 50'(mag1[33:0]) * 50'(alpha[31:16]);
			pb_s1   <= 50'(mag1[33:0]) * 50'(alpha[15:0]);
			neg1_s1 <= sum_q[34];
		end
		if (cmd.step_sum) begin
			s_s2 <= 53'(signed'(ctr_rv_q)) +
			        (neg1_s1 ? -53'(signed'({2'b0, t_w})) : 53'(signed'({2'b0, t_w})));
		end
		if (cmd.step_abs) begin
			m_s3    <= mag2[47:0];
			big_s3  <= |mag2[51:48];
			neg_s3  <= s_s2[52];
			zero_s3 <= (mag2 == '0) || (inv_beta == '0);
		end
		if (cmd.step_mul2) begin
			hi_s4 <= 64'(m_s3) * 64'(inv_beta[31:16]);
			lo_s4 <= 64'(m_s3) * 64'(inv_beta[15:0]);
		end
		if (cmd.load_out) begin
			out_q.new_value <= new_v;
			out_q.last_cell <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load_out) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

/* bench/jacobi_7pt_stencil_sweep_test.sv */
// testbench for the 7-point jacobi sweep: a short table of directed beats,
// then random sweeps checked against a cycle-free model of the stencil update
// depends on jac_pkg and jacobi_7pt_stencil_sweep
`timescale 1ns / 100ps

module jacobi_7pt_stencil_sweep_test;
	import jac_pkg::*;

	localparam int STORE_DEPTH = 2 * MAX_X * MAX_Y + 1;

	typedef struct {
		logic signed [31:0] fv;
		logic signed [31:0] rv;
		bit                 obs;
	} grid_cell_t;

	typedef struct {
		bit          is_cfg;
		cfg_reg_t    reg_idx;
		logic [31:0] wdata;
		in_beat_t    beat;
		bit          chk;
		logic [31:0] want;
	} script_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	// model state
	grid_cell_t  cells [STORE_DEPTH];
	int unsigned sweep_pos, cen_x, cen_y, cen_z;
	logic [6:0]  size_x_reg, size_y_reg, size_z_reg;
	logic [31:0] alpha_reg, inv_beta_reg;

	out_beat_t   pending_values[$];
	logic [31:0] typed_want[int];
	script_row_t script[$];
	int          beats_offered;
	int          beats_taken;
	int          mismatches;
	int          burst_left;
	bit          hold_req;

	jacobi_7pt_stencil_sweep i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int unsigned size_in_use(input logic [6:0] v, input int unsigned mx);
		if (v < 7'd3) return 3;
		if (v > mx) return mx;
		return v;
	endfunction

	function automatic longint field_at(input int unsigned pos);
		return longint'(cells[pos % STORE_DEPTH].fv);
	endfunction

	// (rhs + alpha*sum)*inv_beta, both products rounded half away from zero
	function automatic logic [31:0] relax_cell(input longint nsum, input longint rhs);
		bit neg;
		longint unsigned m, t, hi, r;
		longint s;
		neg = nsum < 0;
		m = neg ? -nsum : nsum;
		t = m * 64'(alpha_reg[31:16]) + ((m * 64'(alpha_reg[15:0]) + 64'h8000) >> 16);
		s = rhs + (neg ? -longint'(t) : longint'(t));
		neg = s < 0;
		m = neg ? -s : s;
		if (inv_beta_reg == 0 || m == 0) return 32'd0;
		if (m >= (64'd1 << 48)) begin
			r = '1;
		end else begin
			hi = m * 64'(inv_beta_reg[31:16]);
			if (hi >= (64'd1 << 33)) r = '1;
			else r = hi + ((m * 64'(inv_beta_reg[15:0]) + 64'h8000) >> 16);
		end
		if (neg) begin
			if (r > 64'h8000_0000) r = 64'h8000_0000;
			r = 64'd0 - r;
			return r[31:0];
		end
		if (r > 64'h7fff_ffff) r = 64'h7fff_ffff;
		return r[31:0];
	endfunction

	task automatic sweep_step(input in_beat_t b, output bit has, output out_beat_t r);
		int unsigned sx, sy, sz, plane, total, p, c;
		longint nsum;
		sx = size_in_use(size_x_reg, MAX_X);
		sy = size_in_use(size_y_reg, MAX_Y);
		sz = size_in_use(size_z_reg, MAX_Z);
		plane = sx * sy;
		total = plane * sz;
		p = sweep_pos;
		has = 1'b0;
		r = '0;
		if (p < total && !b.is_padding) begin
			cells[p % STORE_DEPTH].fv = b.field_value;
			cells[p % STORE_DEPTH].rv = b.rhs_value;
			cells[p % STORE_DEPTH].obs = b.solid;
		end else begin
			cells[p % STORE_DEPTH] = '{32'sd0, 32'sd0, 1'b0};
		end
		if (p < plane) begin
			sweep_pos = p + 1;
			return;
		end
		has = 1'b1;
		c = p - plane;
		if (cen_x == 0 || cen_x == sx - 1 || cen_y == 0 || cen_y == sy - 1 ||
				cen_z == 0 || cen_z == sz - 1) begin
			r.new_value = cells[c % STORE_DEPTH].fv;
		end else if (cells[c % STORE_DEPTH].obs) begin
			r.new_value = '0;
		end else begin
			nsum = field_at(c - 1) + field_at(c + 1) + field_at(c - sx) + field_at(c + sx) +
				field_at(c - plane) + field_at(c + plane);
			r.new_value = relax_cell(nsum, longint'(cells[c % STORE_DEPTH].rv));
		end
		r.last_cell = (c + 1 >= total);
		if (r.last_cell) begin
			sweep_pos = 0;
			cen_x = 0;
			cen_y = 0;
			cen_z = 0;
		end else begin
			sweep_pos = p + 1;
			cen_x++;
			if (cen_x >= sx) begin
				cen_x = 0;
				cen_y++;
				if (cen_y >= sy) begin
					cen_y = 0;
					cen_z++;
				end
			end
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40)
			$display("mismatch on %s at beat %0d: got %h want %h", what, beats_taken, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : watch
		out_beat_t got;
		out_beat_t want;
		bit has;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = out_data;
				if (pending_values.size() == 0) begin
					flag_mismatch("result with none pending", got.new_value, 32'd0);
				end else begin
					want = pending_values.pop_front();
					if (got.new_value !== want.new_value)
						flag_mismatch("new_value", got.new_value, want.new_value);
					if (got.last_cell !== want.last_cell)
						flag_mismatch("last_cell", 32'(got.last_cell), 32'(want.last_cell));
				end
			end
			if (in_valid && in_ready) begin
				sweep_step(in_data, has, want);
				if (has) begin
					if (typed_want.exists(beats_taken)) want.new_value = typed_want[beats_taken];
					pending_values.push_back(want);
				end
				beats_taken++;
			end
		end
	end

	// receiver: rotating stall pattern, plus one long hold on request
	initial begin : receiver
		int cyc;
		cyc = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				case ((cyc / 97) % 4)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (cyc % 7 != 0);
				endcase
			end
		end
	end

	task automatic send(input in_beat_t b);
		int gap;
		in_valid <= 1'b1;
		in_data <= b;
		beats_offered++;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 20);
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// idle until every result is in; beats of the first plane leave nothing pending
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_values.size() != 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SIZE_X: size_x_reg = d[6:0];
			REG_SIZE_Y: size_y_reg = d[6:0];
			REG_SIZE_Z: size_z_reg = d[6:0];
			REG_ALPHA: alpha_reg = d;
			REG_INV_BETA: inv_beta_reg = d;
			default: ;
		endcase
		if (idx == REG_SIZE_X || idx == REG_SIZE_Y || idx == REG_SIZE_Z) begin
			sweep_pos = 0;
			cen_x = 0;
			cen_y = 0;
			cen_z = 0;
		end
	endtask

	task automatic add_cfg(input cfg_reg_t idx, input logic [31:0] d);
		script_row_t row;
		row = '{1'b1, idx, d, '0, 1'b0, 32'd0};
		script.push_back(row);
	endtask

	task automatic add_beat(input logic [31:0] f, input logic [31:0] rv, input bit obs,
			input bit pad, input bit chk, input logic [31:0] want);
		script_row_t row;
		row = '{1'b0, REG_SIZE_X, 32'd0, '{f, rv, obs, pad}, chk, want};
		script.push_back(row);
	endtask

	function automatic logic [31:0] pick_value(input int mode);
		int sel;
		sel = (mode == 2) ? $urandom_range(0, 1) : mode;
		if ($urandom_range(0, 40) == 0) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
		if (sel == 0) return $urandom;
		return 32'($urandom_range(0, 2097152)) - 32'd1048576;
	endfunction

	function automatic logic [31:0] pick_weight(input logic [31:0] usual);
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hffff_ffff;
			2: return $urandom;
			3: return usual;
			default: return $urandom_range(0, 262144);
		endcase
	endfunction

	function automatic logic [31:0] pick_size();
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2);
		return $urandom_range(3, 6);
	endfunction

	// one sweep of grid beats then a plane of flush beats; optionally cut short,
	// reweighted halfway, or with the receiver held off early on
	task automatic run_sweep(input int mode, input int cut_at, input bit reweigh,
			input bit squeeze);
		int unsigned plane, total;
		int p;
		in_beat_t b;
		plane = size_in_use(size_x_reg, MAX_X) * size_in_use(size_y_reg, MAX_Y);
		total = plane * size_in_use(size_z_reg, MAX_Z);
		for (p = 0; p < total + plane; p++) begin
			if (p == cut_at) begin
				drain();
				write_reg(REG_SIZE_Y, size_y_reg);
				return;
			end
			if (reweigh && p == total / 2) begin
				drain();
				write_reg(REG_ALPHA, pick_weight(32'd65536));
			end
			if (squeeze && p == plane + 2) hold_req = 1'b1;
			b.field_value = pick_value(mode);
			b.rhs_value = pick_value(mode);
			if (p < total) begin
				b.solid = ($urandom_range(0, 9) == 0);
				b.is_padding = ($urandom_range(0, 19) == 0);
			end else begin
				b.solid = $urandom_range(0, 1);
				b.is_padding = ($urandom_range(0, 3) != 0);
			end
			send(b);
		end
	endtask

	initial begin : stimulus
		int i;
		int unsigned total;
		script_row_t row;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_req = 1'b0;
		mismatches = 0;
		beats_offered = 0;
		beats_taken = 0;
		burst_left = 0;
		for (i = 0; i < STORE_DEPTH; i++) cells[i] = '{32'sd0, 32'sd0, 1'b0};
		sweep_pos = 0;
		cen_x = 0;
		cen_y = 0;
		cen_z = 0;
		size_x_reg = 7'd64;
		size_y_reg = 7'd64;
		size_z_reg = 7'd64;
		alpha_reg = 32'd65536;
		inv_beta_reg = 32'd10923;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3x3 grid: the bottom plane is all boundary and passes straight through
		add_cfg(REG_SIZE_X, 32'd3);
		add_cfg(REG_SIZE_Y, 32'd3);
		add_cfg(REG_SIZE_Z, 32'd3);
		add_cfg(REG_ALPHA, 32'd65536);
		add_cfg(REG_INV_BETA, 32'd10923);
		add_beat(32'h7fff_ffff, 32'h0000_0000, 0, 0, 0, 0);
		add_beat(32'h8000_0000, 32'hffff_ffff, 0, 0, 0, 0);
		add_beat(32'h0000_0000, 32'h7fff_ffff, 1, 0, 0, 0);
		add_beat(32'hffff_ffff, 32'h8000_0000, 1, 0, 0, 0);
		add_beat(32'h1234_5678, 32'h1111_1111, 1, 1, 0, 0);
		add_beat(32'h0001_0000, 32'h7fff_ffff, 0, 0, 0, 0);
		add_beat(32'hfffe_0000, 32'h8000_0000, 0, 0, 0, 0);
		add_beat(32'h0003_0000, 32'h0000_0001, 0, 0, 0, 0);
		add_beat(32'h0000_8000, 32'h0000_0000, 0, 0, 0, 0);
		add_beat(32'h0006_0000, 32'h0000_0000, 0, 0, 1, 32'h7fff_ffff);
		add_beat(32'h0006_0000, 32'h0000_0000, 0, 0, 1, 32'h8000_0000);
		add_beat(32'h0006_0000, 32'h0000_0000, 0, 0, 1, 32'h0000_0000);
		add_beat(32'h0006_0000, 32'h0000_0000, 0, 0, 1, 32'hffff_ffff);
		add_beat(32'h0000_0000, 32'h0003_0000, 0, 0, 1, 32'h0000_0000);
		add_beat(32'h0006_0000, 32'h0000_0000, 0, 0, 1, 32'h0001_0000);
		add_beat(32'h0006_0000, 32'h0000_0000, 0, 0, 1, 32'hfffe_0000);
		add_beat(32'h0006_0000, 32'h0000_0000, 0, 0, 1, 32'h0003_0000);
		add_beat(32'h0006_0000, 32'h0000_0000, 0, 0, 1, 32'h0000_8000);
		add_beat(32'h0006_0000, 32'h0000_0000, 0, 0, 0, 0);
		add_beat(32'h0006_0000, 32'h0000_0000, 0, 0, 0, 0);
		add_beat(32'h0006_0000, 32'h0000_0000, 0, 0, 0, 0);
		add_beat(32'h0006_0000, 32'h0000_0000, 0, 0, 0, 0);
		add_beat(32'h0006_0000, 32'h0000_0000, 0, 0, 0, 0);
		add_beat(32'h0000_0000, 32'h0000_0000, 0, 1, 0, 0);
		add_beat(32'h0000_0000, 32'h0000_0000, 0, 1, 0, 0);
		// size write mid-sweep restarts it
		add_cfg(REG_SIZE_X, 32'd3);

		foreach (script[k]) begin
			row = script[k];
			if (row.is_cfg) begin
				drain();
				write_reg(row.reg_idx, row.wdata);
			end else begin
				if (row.chk) typed_want[beats_offered] = row.want;
				send(row.beat);
			end
		end

		// widest x (out of range, clamps to the maximum) with the long receiver hold
		drain();
		write_reg(REG_SIZE_X, 32'd127);
		write_reg(REG_SIZE_Y, 32'd3);
		write_reg(REG_SIZE_Z, 32'd3);
		run_sweep(1, -1, 1'b0, 1'b1);

		while (beats_offered < 1300) begin
			drain();
			write_reg(REG_SIZE_X, pick_size());
			write_reg(REG_SIZE_Y, pick_size());
			write_reg(REG_SIZE_Z, pick_size());
			write_reg(REG_ALPHA, pick_weight(32'd65536));
			write_reg(REG_INV_BETA, pick_weight(32'd10923));
			total = size_in_use(size_x_reg, MAX_X) * size_in_use(size_y_reg, MAX_Y) *
				size_in_use(size_z_reg, MAX_Z);
			run_sweep($urandom_range(0, 2),
				($urandom_range(0, 7) == 0) ? int'($urandom_range(1, total)) : -1,
				($urandom_range(0, 5) == 0), 1'b0);
		end

		drain();
		if (pending_values.size() != 0) flag_mismatch("results never seen", pending_values.size(), 0);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/jac_pkg.sv
sv/jac_ram.sv
sv/jac_ctrl.sv
sv/jac_dp.sv
sv/jacobi_7pt_stencil_sweep.sv
bench/jacobi_7pt_stencil_sweep_test.sv
